FILE: sv/ust_pkg.sv
`default_nettype none
package ust_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int DATA_W   = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } op_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   position;
    logic               refused;
    logic               changed;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: sv/ust_ram.sv
`default_nettype none
module ust_ram (
  input  wire logic                      clk,
  input  wire ust_pkg::ram_req_t         ram,
  output logic [ust_pkg::DATA_W-1:0]     rd_data
);
  import ust_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ram.we) begin
      mem[ram.waddr] <= ram.wdata;
    end
    rd_data <= mem[ram.raddr];
  end

endmodule
`default_nettype wire

FILE: sv/ust_ctrl.sv
`default_nettype none
module ust_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire ust_pkg::op_t          req,
  output logic                       res_valid,
  input  wire logic                  res_take,
  output ust_pkg::rsp_t              res,
  output ust_pkg::ram_req_t          ram,
  input  wire logic [ust_pkg::DATA_W-1:0] rd_data
);
  import ust_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] scan;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             wv;
  logic [IDX_W-1:0] wa;
  op_t              op;

  logic             hit_now;
  logic             scan_more;
  logic             miss_now;
  logic             has_room;
  logic [CNT_W-1:0] scan_prev;

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign hit_now   = cmp_vld && (rd_data == DATA_W'(op.value));
  assign scan_more = (scan < held);
  assign miss_now  = (state == S_SEARCH) && !hit_now && !scan_more && !cmp_vld;
  assign has_room  = (held < CNT_W'(CAPACITY));
  assign scan_prev = scan - CNT_W'(1);

  always_comb begin
    ram.we    = 1'b0;
    ram.waddr = wa;
    ram.wdata = rd_data;
    ram.raddr = scan[IDX_W-1:0];
    if (state == S_SHIFT) begin
      ram.we = wv;
    end else if (miss_now && (op.kind == KIND_INSERT) && has_room) begin
      ram.we    = 1'b1;
      ram.waddr = held[IDX_W-1:0];
      ram.wdata = DATA_W'(op.value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      held    <= '0;
      cmp_vld <= 1'b0;
      wv      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req;
            scan    <= '0;
            cmp_vld <= 1'b0;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit_now) begin
            cmp_vld      <= 1'b0;
            res.found    <= 1'b1;
            res.position <= POS_W'(cmp_idx);
            res.refused  <= 1'b0;
            res.changed  <= 1'b0;
            res.count    <= COUNT_W'(held);
            if (op.kind == KIND_REMOVE) begin
              scan  <= CNT_W'(cmp_idx) + CNT_W'(1);
              wv    <= 1'b0;
              state <= S_SHIFT;
            end else begin
              state <= S_DONE;
            end
          end else if (scan_more) begin
            cmp_vld <= 1'b1;
            cmp_idx <= scan[IDX_W-1:0];
            scan    <= scan + CNT_W'(1);
          end else if (cmp_vld) begin
            cmp_vld <= 1'b0;
          end else begin
            res.found    <= 1'b0;
            res.position <= '0;
            res.refused  <= 1'b0;
            res.changed  <= 1'b0;
            res.count    <= COUNT_W'(held);
            if (op.kind == KIND_INSERT) begin
              if (has_room) begin
                held         <= held + CNT_W'(1);
                res.position <= POS_W'(held);
                res.changed  <= 1'b1;
                res.count    <= COUNT_W'(held + CNT_W'(1));
              end else begin
                res.refused <= 1'b1;
              end
            end
            state <= S_DONE;
          end
        end
        S_SHIFT: begin
          if (scan_more) begin
            wv   <= 1'b1;
            wa   <= scan_prev[IDX_W-1:0];
            scan <= scan + CNT_W'(1);
          end else if (wv) begin
            wv <= 1'b0;
          end else begin
            held        <= held - CNT_W'(1);
            res.changed <= 1'b1;
            res.count   <= COUNT_W'(held - CNT_W'(1));
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: sv/unique_value_set_table.sv
// Bounded set of signed 32-bit values kept in insertion order in one 64-entry
// synchronous memory. Each item is an insert (kind 0), remove (kind 1) or
// lookup (kind 2; kind 3 acts as a lookup), and gives exactly one result item
// with found, position, refused, changed and the count held afterwards. The
// memory has one read port, so held entries are scanned one per cycle up to
// the match (all held entries on a miss). A remove that hits then moves each
// later entry down one place, one per cycle. Items are handled one at a time;
// a finished result sits in an output register, so the next item is taken
// while it waits. No clearing pass is needed after reset.
`default_nettype none
module unique_value_set_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ust_pkg::op_t  req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ust_pkg::rsp_t      rsp
);
  import ust_pkg::*;

  logic              res_valid;
  logic              res_take;
  rsp_t              res;
  ram_req_t          ram;
  logic [DATA_W-1:0] rd_data;

  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  ust_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ram       (ram),
    .rd_data   (rd_data)
  );

  ust_ram u_ram (
    .clk     (clk),
    .ram     (ram),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: verif/tb_unique_value_set_table.sv
`timescale 1ns / 100ps
module tb_unique_value_set_table;
  import ust_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int HOLD_LONG = 300;
  localparam int ITEMS_PER_PHASE = 260;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  op_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  unique_value_set_table uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  op_t op_backlog[$];
  rsp_t rsp_due[$];
  logic signed [DATA_W-1:0] recent_vals[$];

  logic [DATA_W-1:0] set_vals [CAPACITY];
  int set_held = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int rsp_hold_left = 0;
  int errors = 0;
  int queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_lookup = 0;
  int n_hits = 0;
  int n_refused = 0;
  int n_full = 0;
  rsp_t rsp_want;

  function automatic rsp_t set_apply(op_t op);
    rsp_t r;
    int hit_at;
    int i;
    r = '0;
    hit_at = -1;
    for (i = 0; i < set_held && hit_at < 0; i++) begin
      if (set_vals[i] == op.value) begin
        hit_at = i;
      end
    end
    if (hit_at >= 0) begin
      r.found = 1'b1;
      r.position = hit_at[POS_W-1:0];
      n_hits++;
    end
    if (op.kind == KIND_INSERT) begin
      n_insert++;
      if (hit_at < 0) begin
        if (set_held < CAPACITY) begin
          set_vals[set_held] = op.value;
          r.position = set_held[POS_W-1:0];
          set_held++;
          r.changed = 1'b1;
        end else begin
          r.refused = 1'b1;
          n_refused++;
        end
      end
    end else if (op.kind == KIND_REMOVE) begin
      n_remove++;
      if (hit_at >= 0) begin
        for (i = hit_at; i + 1 < set_held; i++) begin
          set_vals[i] = set_vals[i + 1];
        end
        set_held--;
        r.changed = 1'b1;
      end
    end else begin
      n_lookup++;
    end
    if (set_held == CAPACITY) begin
      n_full++;
    end
    r.count = set_held[COUNT_W-1:0];
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_due.push_back(set_apply(req));
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= op_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_results++;
        if (rsp_due.size() == 0) begin
          $display("%0t ns: unexpected result item %p", $time, rsp);
          errors++;
        end else begin
          rsp_want = rsp_due.pop_front();
          if (rsp.found !== rsp_want.found) begin
            $display("%0t ns: found expected %0d actual %0d", $time, rsp_want.found, rsp.found);
            errors++;
          end
          if (rsp.position !== rsp_want.position) begin
            $display("%0t ns: position expected %0d actual %0d", $time,
                     rsp_want.position, rsp.position);
            errors++;
          end
          if (rsp.refused !== rsp_want.refused) begin
            $display("%0t ns: refused expected %0d actual %0d", $time,
                     rsp_want.refused, rsp.refused);
            errors++;
          end
          if (rsp.changed !== rsp_want.changed) begin
            $display("%0t ns: changed expected %0d actual %0d", $time,
                     rsp_want.changed, rsp.changed);
            errors++;
          end
          if (rsp.count !== rsp_want.count) begin
            $display("%0t ns: count expected %0d actual %0d", $time, rsp_want.count, rsp.count);
            errors++;
          end
        end
      end
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
      end
      rsp_stall <= (rsp_hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic add_op(logic [1:0] kind, logic signed [DATA_W-1:0] value);
    op_t o;
    o.kind = kind;
    o.value = value;
    op_backlog.push_back(o);
    queued++;
  endtask

  function automatic logic [1:0] lookup_kind();
    return ($urandom_range(3) == 0) ? KIND_SPARE : KIND_LOOKUP;
  endfunction

  function automatic logic signed [DATA_W-1:0] edge_value();
    case ($urandom_range(4))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_recent();
    if (recent_vals.size() == 0) begin
      return $urandom;
    end
    return recent_vals[$urandom_range(recent_vals.size() - 1)];
  endfunction

  // distinct values, enough of them to fill the store most of the time
  task automatic fill_burst();
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] stride;
    logic signed [DATA_W-1:0] v;
    int n;
    int i;
    n = $urandom_range(56, 72);
    base = $urandom;
    stride = ($urandom_range(1) == 0) ? 32'sd1 : ($urandom | 32'sd1);
    recent_vals.delete();
    for (i = 0; i < n; i++) begin
      v = base + i * stride;
      recent_vals.push_back(v);
      add_op(KIND_INSERT, v);
      if ($urandom_range(9) == 0) begin
        add_op(lookup_kind(), pick_recent());
      end
      if ($urandom_range(19) == 0) begin
        add_op(KIND_INSERT, pick_recent());
      end
    end
  endtask

  task automatic drain_burst();
    int m;
    int idx;
    m = $urandom_range(recent_vals.size() / 2, recent_vals.size());
    repeat (m) begin
      idx = $urandom_range(recent_vals.size() - 1);
      add_op(KIND_REMOVE, recent_vals[idx]);
      recent_vals.delete(idx);
      if ($urandom_range(7) == 0) begin
        add_op(lookup_kind(), pick_recent());
      end
      if ($urandom_range(11) == 0) begin
        add_op(KIND_REMOVE, $urandom);
      end
    end
  endtask

  task automatic mixed_burst();
    logic signed [DATA_W-1:0] v;
    logic [1:0] kind;
    int sel;
    repeat ($urandom_range(20, 40)) begin
      sel = $urandom_range(19);
      if (sel < 12) begin
        v = pick_recent();
      end else if (sel < 15) begin
        v = edge_value();
      end else begin
        v = $urandom;
      end
      sel = $urandom_range(9);
      if (sel < 4) begin
        kind = KIND_INSERT;
      end else if (sel < 7) begin
        kind = KIND_REMOVE;
      end else begin
        kind = lookup_kind();
      end
      if (kind == KIND_INSERT && $urandom_range(1) == 0) begin
        recent_vals.push_back(v);
      end
      add_op(kind, v);
    end
  endtask

  task automatic run_random(int target);
    int start;
    int sel;
    start = queued;
    fill_burst();
    while (queued - start < target) begin
      sel = $urandom_range(9);
      if (sel < 3) begin
        fill_burst();
      end else if (sel < 6 && recent_vals.size() != 0) begin
        drain_burst();
      end else if (sel < 9) begin
        mixed_burst();
      end else begin
        repeat ($urandom_range(3, 8)) begin
          add_op(2'($urandom_range(3)), $urandom);
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (op_backlog.size() != 0 || req_valid || rsp_due.size() != 0);
  endtask

  initial begin
    int mark;
    send_idle_pct = 23;
    recv_idle_pct = 50;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty store, extremes, duplicates, spare kind, removes at each end
    add_op(KIND_LOOKUP, 32'sd0);
    add_op(KIND_REMOVE, 32'sd5);
    add_op(KIND_INSERT, 32'sh8000_0000);
    add_op(KIND_INSERT, 32'sh7fff_ffff);
    add_op(KIND_INSERT, 32'sd0);
    add_op(KIND_INSERT, -32'sd1);
    add_op(KIND_INSERT, 32'sh7fff_ffff);
    add_op(KIND_LOOKUP, -32'sd1);
    add_op(KIND_SPARE, 32'sh8000_0000);
    add_op(KIND_LOOKUP, 32'sd1);
    add_op(KIND_REMOVE, 32'sd0);
    add_op(KIND_LOOKUP, -32'sd1);
    add_op(KIND_REMOVE, 32'sd12345);
    add_op(KIND_REMOVE, 32'sh8000_0000);
    add_op(KIND_REMOVE, -32'sd1);
    add_op(KIND_SPARE, 32'sh7fff_ffff);
    add_op(KIND_REMOVE, 32'sh7fff_ffff);
    add_op(KIND_INSERT, 32'sd1);
    add_op(KIND_REMOVE, 32'sd1);
    add_op(KIND_LOOKUP, 32'sd1);
    wait_drained();

    mark = n_accepted + 60;
    run_random(ITEMS_PER_PHASE);
    while (n_accepted < mark) @(negedge clk);
    // long receiver hold while items keep coming
    rsp_hold_left = HOLD_LONG;
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 23;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    repeat (200) @(negedge clk);
    $display("ran %0d items (%0d inserts, %0d removes, %0d lookups), %0d results checked",
             n_accepted, n_insert, n_remove, n_lookup, n_results);
    $display("%0d hits, %0d refused inserts, %0d results with the store full",
             n_hits, n_refused, n_full);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
sv/ust_pkg.sv
sv/ust_ram.sv
sv/ust_ctrl.sv
sv/unique_value_set_table.sv
verif/tb_unique_value_set_table.sv
